FILE: design/spe_pkg.sv
// shared constants, types and control structs for the set partition enumerator
package spe_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CODE_W       = 4;
    localparam int SIZE_W       = 5;
    localparam int CODES_W      = MAX_ELEMENTS * CODE_W;
    localparam logic [CODE_W-1:0] CODE_TOP = {CODE_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_BUMP,
        OP_FILL
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  rd_idx;
        logic [CODE_W-1:0] fill_max;
    } ctrl_t;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] max_val;
        logic [CODE_W-1:0] pm_rd;
    } stat_t;

endpackage

FILE: design/spe_datapath.sv
// code and prefix-maximum storage with the shared compare/increment unit
module spe_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spe_pkg::ctrl_t         ctrl,
    output spe_pkg::stat_t         stat,
    output logic [spe_pkg::CODES_W-1:0] codes
);
    import spe_pkg::*;

    logic [CODE_W-1:0] codes_reg [MAX_ELEMENTS];
    logic [CODE_W-1:0] pmax_reg  [MAX_ELEMENTS];
    logic [CODE_W-1:0] cur_code;
    logic [CODE_W-1:0] bumped;

    // one code and one prefix maximum are looked at per cycle
    assign cur_code      = codes_reg[ctrl.idx];
    assign stat.pm_rd    = pmax_reg[ctrl.rd_idx];
    assign bumped        = cur_code + CODE_W'(1);
    assign stat.hit      = (cur_code <= stat.pm_rd) && (cur_code != CODE_TOP);
    assign stat.max_val  = (bumped > stat.pm_rd) ? bumped : stat.pm_rd;

    always_comb
    begin
        for (int k = 0; k < MAX_ELEMENTS; k++)
        begin
            codes[k*CODE_W +: CODE_W] = codes_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_ELEMENTS; k++)
            begin
                codes_reg[k] <= '0;
                pmax_reg[k]  <= '0;
            end
        end
        else
        begin
            case (ctrl.op)
                OP_CLEAR:
                begin
                    for (int k = 0; k < MAX_ELEMENTS; k++)
                    begin
                        codes_reg[k] <= '0;
                        pmax_reg[k]  <= '0;
                    end
                end
                OP_BUMP:
                begin
                    codes_reg[ctrl.idx] <= bumped;
                    pmax_reg[ctrl.idx]  <= stat.max_val;
                end
                OP_FILL:
                begin
                    codes_reg[ctrl.idx] <= '0;
                    pmax_reg[ctrl.idx]  <= ctrl.fill_max;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: design/set_partition_enumerator.sv
// set partition enumerator top level: sequencer, size register and result register
//
// Emits set partitions as restricted growth strings in lexicographic order, one
// result per request. A restart clears the codes and returns the single-block
// partition. An advance once the enumeration is exhausted, or an advance on a
// single-element set, goes straight to the finish state. Any other advance walks
// the positions downward from the last element, one position per cycle through a
// single compare/increment unit. It then zeroes the tail one element per cycle.
// When no position can be raised, the result is flagged exhausted and repeats the
// last partition until a restart. The request side stalls while an item is being
// worked and takes the next request the cycle after the load. A result still held
// by the receiver delays that load. The result register lets a new request in
// while the previous result still waits to be taken.
module set_partition_enumerator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        set_size_we,
    input  logic [spe_pkg::SIZE_W-1:0]  set_size_data,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        restart,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [spe_pkg::CODES_W-1:0] partition_codes,
    output logic [spe_pkg::SIZE_W-1:0]  block_count,
    output logic                        exhausted
);
    import spe_pkg::*;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   set_size_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CODE_W-1:0]   fill_reg, fill_next;
    logic                done_reg, done_next;
    logic                exh_reg, exh_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [CODES_W-1:0]  codes_out_reg;
    logic [SIZE_W-1:0]   count_out_reg;
    logic                exh_out_reg;
    logic                load_out;

    logic [SIZE_W-1:0]   n_eff;
    logic [IDX_W-1:0]    last_idx;
    logic [CODES_W-1:0]  codes_raw;
    logic [CODES_W-1:0]  codes_masked;
    ctrl_t               ctrl;
    stat_t               stat;

    spe_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .codes (codes_raw)
    );

    // size 0 acts as 1, anything above the array depth acts as the depth
    assign n_eff = (set_size_reg == '0) ? SIZE_W'(1) :
                   (set_size_reg > SIZE_W'(MAX_ELEMENTS)) ? SIZE_W'(MAX_ELEMENTS) :
                   set_size_reg;
    assign last_idx = IDX_W'(n_eff - SIZE_W'(1));

    always_comb
    begin
        for (int k = 0; k < MAX_ELEMENTS; k++)
        begin
            codes_masked[k*CODE_W +: CODE_W] =
                (SIZE_W'(k) < n_eff) ? codes_raw[k*CODE_W +: CODE_W] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            set_size_reg  <= SIZE_W'(4);
            idx_reg       <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            exh_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            exh_reg       <= exh_next;
            rsp_valid_reg <= rsp_valid_next;
            if (set_size_we)
            begin
                set_size_reg <= set_size_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            codes_out_reg <= codes_masked;
            count_out_reg <= SIZE_W'(stat.pm_rd) + SIZE_W'(1);
            exh_out_reg   <= exh_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        done_next     = done_reg;
        exh_next      = exh_reg;
        load_out      = 1'b0;
        ctrl.op       = OP_NONE;
        ctrl.idx      = idx_reg;
        ctrl.rd_idx   = (state_reg == ST_SCAN) ? (idx_reg - IDX_W'(1)) : last_idx;
        ctrl.fill_max = fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (restart)
                    begin
                        ctrl.op    = OP_CLEAR;
                        done_next  = 1'b0;
                        exh_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else if (done_reg)
                    begin
                        exh_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (last_idx == '0)
                    begin
                        // a single element has only one partition
                        done_next  = 1'b1;
                        exh_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = last_idx;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (stat.hit)
                begin
                    ctrl.op   = OP_BUMP;
                    fill_next = stat.max_val;
                    exh_next  = 1'b0;
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_FILL;
                    end
                end
                else if (idx_reg == IDX_W'(1))
                begin
                    done_next  = 1'b1;
                    exh_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_FILL:
            begin
                // tail codes go to zero and inherit the new maximum
                ctrl.op = OP_FILL;
                if (idx_reg == last_idx)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    assign req_stall       = (state_reg != ST_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign partition_codes = codes_out_reg;
    assign block_count     = count_out_reg;
    assign exhausted       = exh_out_reg;

    // a new result only appears after the sequencer finishes an item
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result appeared without a finished item");

    // block count stays within one..max elements
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (block_count != '0) && (block_count <= SIZE_W'(MAX_ELEMENTS)))
        else $error("block count out of range");

    // the scan never reaches element zero
    a_scan_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg != '0)
        else $error("scan index reached element zero");

    // exhaustion leaves the done flag set until a restart transfer
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(done_reg) |-> $past(req_valid && !req_stall && restart))
        else $error("done flag cleared without restart");

endmodule
